/* src/dhbd_pkg.sv */
// ----------------------------------------------------------------------------
// dhbd_pkg
// Shared types and constants for the dual H-bridge drive controller.
// ----------------------------------------------------------------------------
package dhbd_pkg;

    typedef enum logic [2:0] {
        MODE_STOP     = 3'd0,
        MODE_FORWARD  = 3'd1,
        MODE_BACKWARD = 3'd2,
        MODE_SPIN     = 3'd3,
        MODE_GRADUAL  = 3'd4,
        MODE_STEER    = 3'd5,
        MODE_SLOW     = 3'd6,
        MODE_FAST     = 3'd7
    } t_mode;

    typedef enum logic [1:0] {
        DRV_STOP = 2'd0,
        DRV_FWD  = 2'd1,
        DRV_REV  = 2'd2,
        DRV_TURN = 2'd3
    } t_drive;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_DIV,
        ST_UPDATE
    } t_state;

    // config register indexes
    localparam logic CFG_LEFT_SCALE  = 1'b0;
    localparam logic CFG_RIGHT_SCALE = 1'b1;

    localparam logic [6:0] LEFT_SCALE_RST  = 7'd80;
    localparam logic [6:0] RIGHT_SCALE_RST = 7'd100;
    localparam logic [6:0] PCT_FULL        = 7'd100;

    // bridge pin bits
    localparam int PIN_LF = 0;
    localparam int PIN_LR = 1;
    localparam int PIN_RF = 2;
    localparam int PIN_RR = 3;

    // floor(q / 10000) = (q * RECIP_10K) >> RECIP_SHIFT, exact for q < 2^20
    localparam logic [20:0] RECIP_10K   = 21'd1717987;
    localparam int          RECIP_SHIFT = 34;

    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic div;
        logic update;
    } t_dp_cmd;

    typedef struct packed {
        logic in_needs_mul;
    } t_dp_stat;

endpackage

/* src/dhbd_if.sv */
// ----------------------------------------------------------------------------
// dhbd_if
// Command and result channels of the dual H-bridge drive controller.
// ----------------------------------------------------------------------------
interface dhbd_cmd_if;
    logic              valid;
    logic              ready;
    logic [2:0]        mode;
    logic [6:0]        speed;
    logic              direction;
    logic [6:0]        tightness;
    logic [6:0]        amount;
    logic signed [7:0] turning;

    modport source (output valid, mode, speed, direction, tightness, amount, turning,
                    input ready);
    modport sink   (input valid, mode, speed, direction, tightness, amount, turning,
                    output ready);
endinterface

interface dhbd_res_if;
    logic              valid;
    logic              ready;
    logic              left_fwd_pin;
    logic              left_rev_pin;
    logic              right_fwd_pin;
    logic              right_rev_pin;
    logic [6:0]        left_duty;
    logic [6:0]        right_duty;
    logic signed [8:0] average_speed;
    logic [1:0]        drive_state;

    modport source (output valid, left_fwd_pin, left_rev_pin, right_fwd_pin,
                    right_rev_pin, left_duty, right_duty, average_speed, drive_state,
                    input ready);
    modport sink   (input valid, left_fwd_pin, left_rev_pin, right_fwd_pin,
                    right_rev_pin, left_duty, right_duty, average_speed, drive_state,
                    output ready);
endinterface

/* src/dual_hbridge_drive_controller.sv */
// ----------------------------------------------------------------------------
// dual_hbridge_drive_controller
// Differential drive controller for two H-bridge motor channels.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd  : command words (mode, speed, direction, tightness, amount,
//            turning), taken when valid and ready are both high.
//   o_res  : one result word per command: bridge pins, PWM duties,
//            average held speed and drive state.
//   i_cfg_*: write port for the left/right full-speed scale percents;
//            write only while no command is in flight.
// Timing: one command at a time. Forward, backward, spin and gradual turn
//   run through three scaling steps (speed x factor, x scale, reciprocal
//   multiply for /10000) before the result update; the other commands go
//   straight to the update. The next command is taken only after the
//   result is registered, so no new word is accepted while one is in flight.
// Reset: scales return to 80 and 100, held speeds, duties and pins clear,
//   drive state is stopped, no result is pending.
// Stall: a finished result sits in the output register; the next command
//   is accepted and processed, then waits until that register is drained.
// ----------------------------------------------------------------------------
module dual_hbridge_drive_controller (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [6:0] i_cfg_data,
    dhbd_cmd_if.sink   i_cmd,
    dhbd_res_if.source o_res
);
    import dhbd_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_stat   dp_stat;
    logic [3:0] pins;

    dhbd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd.valid),
        .o_cmd_ready (i_cmd.ready),
        .o_res_valid (o_res.valid),
        .i_res_ready (o_res.ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    dhbd_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_mode          (i_cmd.mode),
        .i_speed         (i_cmd.speed),
        .i_direction     (i_cmd.direction),
        .i_tightness     (i_cmd.tightness),
        .i_amount        (i_cmd.amount),
        .i_turning       (i_cmd.turning),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .o_pins          (pins),
        .o_left_duty     (o_res.left_duty),
        .o_right_duty    (o_res.right_duty),
        .o_average_speed (o_res.average_speed),
        .o_drive_state   (o_res.drive_state)
    );

    assign o_res.left_fwd_pin  = pins[PIN_LF];
    assign o_res.left_rev_pin  = pins[PIN_LR];
    assign o_res.right_fwd_pin = pins[PIN_RF];
    assign o_res.right_rev_pin = pins[PIN_RR];

endmodule

/* src/dhbd_ctrl.sv */
// ----------------------------------------------------------------------------
// dhbd_ctrl
// Sequencer: accepts a command word, steps the scaling datapath, and
// owns the output valid flag.
// ----------------------------------------------------------------------------
module dhbd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    input  dhbd_pkg::t_dp_stat i_stat,
    output dhbd_pkg::t_dp_cmd  o_cmd
);
    import dhbd_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   slot_free;

    assign accept    = i_cmd_valid && (r_state == ST_IDLE);
    assign slot_free = !r_out_valid || i_res_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = i_stat.in_needs_mul ? ST_MUL1 : ST_UPDATE;
                end
            end
            ST_MUL1:   n_state = ST_MUL2;
            ST_MUL2:   n_state = ST_DIV;
            ST_DIV:    n_state = ST_UPDATE;
            ST_UPDATE: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd_ready  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_cmd_ready = 1'b1;
                o_cmd.load  = i_cmd_valid;
            end
            ST_MUL1:   o_cmd.mul1   = 1'b1;
            ST_MUL2:   o_cmd.mul2   = 1'b1;
            ST_DIV:    o_cmd.div    = 1'b1;
            ST_UPDATE: o_cmd.update = slot_free;
            default:   o_cmd        = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.update) begin
            n_out_valid = 1'b1;
        end else if (i_res_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_res_valid = r_out_valid;

endmodule

/* src/dhbd_dp.sv */
// ----------------------------------------------------------------------------
// dhbd_dp
// Datapath: scale registers, held motor state, two scaling lanes and the
// output word register.
// ----------------------------------------------------------------------------
module dhbd_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [6:0]        i_cfg_data,
    input  logic [2:0]        i_mode,
    input  logic [6:0]        i_speed,
    input  logic              i_direction,
    input  logic [6:0]        i_tightness,
    input  logic [6:0]        i_amount,
    input  logic signed [7:0] i_turning,
    input  dhbd_pkg::t_dp_cmd  i_cmd,
    output dhbd_pkg::t_dp_stat o_stat,
    output logic [3:0]        o_pins,
    output logic [6:0]        o_left_duty,
    output logic [6:0]        o_right_duty,
    output logic signed [8:0] o_average_speed,
    output logic [1:0]        o_drive_state
);
    import dhbd_pkg::*;

    function automatic logic [6:0] pct(input logic [6:0] v);
        pct = (v > PCT_FULL) ? PCT_FULL : v;
    endfunction

    function automatic logic signed [8:0] clamp_duty(input logic signed [9:0] v);
        if (v > 10'sd100)     clamp_duty = 9'sd100;
        else if (v < 10'sd0)  clamp_duty = 9'sd0;
        else                  clamp_duty = v[8:0];
    endfunction

    function automatic logic signed [8:0] sat_speed(input logic signed [9:0] v);
        if (v > 10'sd255)       sat_speed = 9'sd255;
        else if (v < -10'sd255) sat_speed = -9'sd255;
        else                    sat_speed = v[8:0];
    endfunction

    // config
    logic [6:0] r_left_scale, r_right_scale;

    // latched command word
    t_mode             r_mode;
    logic [6:0]        r_s;
    logic              r_dir;
    logic [6:0]        r_inner;
    logic [6:0]        r_amount;
    logic signed [7:0] r_turning;

    // scaling lanes
    logic [13:0] r_p_l, r_p_r;
    logic [19:0] r_q_l, r_q_r;
    logic [6:0]  r_r_l, r_r_r;
    logic [6:0]  f_l, f_r;
    logic [40:0] prod_l, prod_r;

    // held state
    logic signed [8:0] r_left_speed, r_right_speed, n_left_speed, n_right_speed;
    logic [6:0]        r_left_duty, r_right_duty, n_left_duty, n_right_duty;
    logic [3:0]        r_pins, n_pins;
    t_drive            r_drive, n_drive;
    logic signed [9:0] sum;
    logic signed [9:0] half;

    // output word
    logic [3:0]        r_o_pins;
    logic [6:0]        r_o_left_duty, r_o_right_duty;
    logic signed [8:0] r_o_avg;
    logic [1:0]        r_o_drive;

    assign o_stat.in_needs_mul = (t_mode'(i_mode) == MODE_FORWARD)
                              || (t_mode'(i_mode) == MODE_BACKWARD)
                              || (t_mode'(i_mode) == MODE_SPIN)
                              || (t_mode'(i_mode) == MODE_GRADUAL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_scale  <= LEFT_SCALE_RST;
            r_right_scale <= RIGHT_SCALE_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_LEFT_SCALE) begin
                r_left_scale <= i_cfg_data;
            end else begin
                r_right_scale <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode    <= t_mode'(i_mode);
            r_s       <= pct(i_speed);
            r_dir     <= i_direction;
            r_inner   <= PCT_FULL - pct(i_tightness);
            r_amount  <= i_amount;
            r_turning <= i_turning;
        end
    end

    // every lane computes s * f * scale / 10000; outer motor uses f = 100
    assign f_l = (r_mode == MODE_GRADUAL && !r_dir) ? r_inner : PCT_FULL;
    assign f_r = (r_mode == MODE_GRADUAL &&  r_dir) ? r_inner : PCT_FULL;
    assign prod_l = r_q_l * RECIP_10K;
    assign prod_r = r_q_r * RECIP_10K;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1) begin
            r_p_l <= r_s * f_l;
            r_p_r <= r_s * f_r;
        end
        if (i_cmd.mul2) begin
            r_q_l <= 20'(r_p_l * pct(r_left_scale));
            r_q_r <= 20'(r_p_r * pct(r_right_scale));
        end
        if (i_cmd.div) begin
            r_r_l <= prod_l[RECIP_SHIFT +: 7];
            r_r_r <= prod_r[RECIP_SHIFT +: 7];
        end
    end

    always_comb begin
        n_left_speed  = r_left_speed;
        n_right_speed = r_right_speed;
        n_left_duty   = r_left_duty;
        n_right_duty  = r_right_duty;
        n_pins        = r_pins;
        n_drive       = r_drive;
        case (r_mode)
            MODE_STOP: begin
                n_pins  = '0;
                n_drive = DRV_STOP;
            end
            MODE_FORWARD, MODE_BACKWARD, MODE_SPIN, MODE_GRADUAL: begin
                n_left_speed  = {2'b00, r_r_l};
                n_right_speed = {2'b00, r_r_r};
                n_left_duty   = r_r_l;
                n_right_duty  = r_r_r;
                n_pins        = '0;
                if (r_mode == MODE_FORWARD) begin
                    n_pins[PIN_LF] = 1'b1;
                    n_pins[PIN_RF] = 1'b1;
                    n_drive        = DRV_FWD;
                end else if (r_mode == MODE_BACKWARD) begin
                    n_pins[PIN_LR] = 1'b1;
                    n_pins[PIN_RR] = 1'b1;
                    n_drive        = DRV_REV;
                end else if (r_mode == MODE_SPIN) begin
                    n_pins[PIN_LF] = r_dir;
                    n_pins[PIN_RR] = r_dir;
                    n_pins[PIN_LR] = !r_dir;
                    n_pins[PIN_RF] = !r_dir;
                    n_drive        = DRV_TURN;
                end else begin
                    n_pins[PIN_LF] = 1'b1;
                    n_pins[PIN_RF] = 1'b1;
                    n_drive        = DRV_TURN;
                end
            end
            MODE_STEER: begin
                n_left_speed  = clamp_duty(10'(r_left_speed) + 10'(r_turning));
                n_right_speed = clamp_duty(10'(r_right_speed) - 10'(r_turning));
                n_left_duty   = n_left_speed[6:0];
                n_right_duty  = n_right_speed[6:0];
            end
            MODE_SLOW: begin
                n_left_speed  = sat_speed(10'(r_left_speed) - $signed({3'b000, r_amount}));
                n_right_speed = sat_speed(10'(r_right_speed) - $signed({3'b000, r_amount}));
            end
            MODE_FAST: begin
                n_left_speed  = sat_speed(10'(r_left_speed) + $signed({3'b000, r_amount}));
                n_right_speed = sat_speed(10'(r_right_speed) + $signed({3'b000, r_amount}));
            end
            default: begin
                n_pins = r_pins;
            end
        endcase
    end

    // halve toward zero
    assign sum  = 10'(n_left_speed) + 10'(n_right_speed);
    assign half = (sum + $signed({9'b0, sum[9]})) >>> 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_speed  <= '0;
            r_right_speed <= '0;
            r_left_duty   <= '0;
            r_right_duty  <= '0;
            r_pins        <= '0;
            r_drive       <= DRV_STOP;
        end else if (i_cmd.update) begin
            r_left_speed  <= n_left_speed;
            r_right_speed <= n_right_speed;
            r_left_duty   <= n_left_duty;
            r_right_duty  <= n_right_duty;
            r_pins        <= n_pins;
            r_drive       <= n_drive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_o_pins       <= n_pins;
            r_o_left_duty  <= n_left_duty;
            r_o_right_duty <= n_right_duty;
            r_o_avg        <= half[8:0];
            r_o_drive      <= n_drive;
        end
    end

    assign o_pins          = r_o_pins;
    assign o_left_duty     = r_o_left_duty;
    assign o_right_duty    = r_o_right_duty;
    assign o_average_speed = r_o_avg;
    assign o_drive_state   = r_o_drive;

endmodule

/* src/dhbd_chk.sv */
// ----------------------------------------------------------------------------
// dhbd_chk
// Port-level checks for the dual H-bridge drive controller.
// ----------------------------------------------------------------------------
module dhbd_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_cmd_valid,
    input logic              i_cmd_ready,
    input logic              i_res_valid,
    input logic              i_res_ready,
    input logic              i_lf,
    input logic              i_lr,
    input logic              i_rf,
    input logic              i_rr,
    input logic [6:0]        i_left_duty,
    input logic signed [8:0] i_avg,
    input logic [1:0]        i_drive
);
    import dhbd_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_left_duty) && $stable(i_avg))
        else $error("stalled result word changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && i_cmd_ready |=> !i_cmd_ready)
        else $error("command taken while previous word in flight");

    a_no_shoot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> !(i_lf && i_lr) && !(i_rf && i_rr) && (i_avg >= -9'sd255))
        else $error("bridge driven both ways or average out of range");

    a_stop_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_drive == DRV_STOP) |-> !i_lf && !i_lr && !i_rf && !i_rr)
        else $error("pins active while stopped");

endmodule

bind dual_hbridge_drive_controller dhbd_chk u_dhbd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_valid (i_cmd.valid),
    .i_cmd_ready (i_cmd.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_lf        (o_res.left_fwd_pin),
    .i_lr        (o_res.left_rev_pin),
    .i_rf        (o_res.right_fwd_pin),
    .i_rr        (o_res.right_rev_pin),
    .i_left_duty (o_res.left_duty),
    .i_avg       (o_res.average_speed),
    .i_drive     (o_res.drive_state)
);

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the dual H-bridge drive controller. Drives command words
// with random gaps, stalls the result channel at random, and checks every
// result word against a cycle-free model of the held speeds, duties, pins
// and drive state. Scale registers change between phases while idle.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dhbd_pkg::*;

    typedef struct {
        t_mode             mode;
        logic [6:0]        speed;
        logic              direction;
        logic [6:0]        tightness;
        logic [6:0]        amount;
        logic signed [7:0] turning;
    } t_drive_cmd;

    typedef struct {
        logic              left_fwd_pin;
        logic              left_rev_pin;
        logic              right_fwd_pin;
        logic              right_rev_pin;
        logic [6:0]        left_duty;
        logic [6:0]        right_duty;
        logic signed [8:0] average_speed;
        logic [1:0]        drive_state;
    } t_drive_res;

    class drive_scoreboard;
        logic [6:0] left_scale;
        logic [6:0] right_scale;
        int         left_speed;
        int         right_speed;
        t_drive     drive_state;
        logic [6:0] left_duty;
        logic [6:0] right_duty;
        logic [3:0] pins;
        t_drive_res expected_q[$];
        int         mismatches;

        function new();
            left_scale  = LEFT_SCALE_RST;
            right_scale = RIGHT_SCALE_RST;
            left_speed  = 0;
            right_speed = 0;
            drive_state = DRV_STOP;
            left_duty   = '0;
            right_duty  = '0;
            pins        = '0;
            mismatches  = 0;
        endfunction

        function void set_scale(logic idx, logic [6:0] value);
            if (idx == CFG_LEFT_SCALE) begin
                left_scale = value;
            end else begin
                right_scale = value;
            end
        endfunction

        function int clip_pct(int v);
            return (v > int'(PCT_FULL)) ? int'(PCT_FULL) : v;
        endfunction

        function int clamp_duty(int v);
            if (v > 100) return 100;
            if (v < 0) return 0;
            return v;
        endfunction

        function int sat_speed(int v);
            if (v > 255) return 255;
            if (v < -255) return -255;
            return v;
        endfunction

        function int full_speed(int s, logic [6:0] scale);
            return s * clip_pct(scale) / 100;
        endfunction

        function void drive_duties();
            left_duty  = 7'(clamp_duty(left_speed));
            right_duty = 7'(clamp_duty(right_speed));
        endfunction

        function void note_command(t_drive_cmd c);
            int         s;
            int         inner;
            int         amt;
            int         trn;
            int         avg;
            t_drive_res r;
            s     = clip_pct(c.speed);
            inner = 100 - clip_pct(c.tightness);
            amt   = c.amount;
            trn   = c.turning;
            case (c.mode)
                MODE_STOP: begin
                    pins        = '0;
                    drive_state = DRV_STOP;
                end
                MODE_FORWARD, MODE_BACKWARD, MODE_SPIN: begin
                    left_speed  = full_speed(s, left_scale);
                    right_speed = full_speed(s, right_scale);
                    drive_duties();
                    pins = '0;
                    if (c.mode == MODE_FORWARD) begin
                        pins[PIN_LF] = 1'b1;
                        pins[PIN_RF] = 1'b1;
                        drive_state  = DRV_FWD;
                    end else if (c.mode == MODE_BACKWARD) begin
                        pins[PIN_LR] = 1'b1;
                        pins[PIN_RR] = 1'b1;
                        drive_state  = DRV_REV;
                    end else begin
                        // spin: right turn runs the left bridge forward
                        pins[PIN_LF] = c.direction;
                        pins[PIN_RR] = c.direction;
                        pins[PIN_LR] = !c.direction;
                        pins[PIN_RF] = !c.direction;
                        drive_state  = DRV_TURN;
                    end
                end
                MODE_GRADUAL: begin
                    if (c.direction) begin
                        left_speed  = full_speed(s, left_scale);
                        right_speed = s * inner * clip_pct(right_scale) / 10000;
                    end else begin
                        right_speed = full_speed(s, right_scale);
                        left_speed  = s * inner * clip_pct(left_scale) / 10000;
                    end
                    drive_duties();
                    pins         = '0;
                    pins[PIN_LF] = 1'b1;
                    pins[PIN_RF] = 1'b1;
                    drive_state  = DRV_TURN;
                end
                MODE_STEER: begin
                    left_speed  = clamp_duty(left_speed + trn);
                    right_speed = clamp_duty(right_speed - trn);
                    drive_duties();
                end
                MODE_SLOW: begin
                    left_speed  = sat_speed(left_speed - amt);
                    right_speed = sat_speed(right_speed - amt);
                end
                default: begin
                    left_speed  = sat_speed(left_speed + amt);
                    right_speed = sat_speed(right_speed + amt);
                end
            endcase
            avg               = (left_speed + right_speed) / 2;
            r.left_fwd_pin    = pins[PIN_LF];
            r.left_rev_pin    = pins[PIN_LR];
            r.right_fwd_pin   = pins[PIN_RF];
            r.right_rev_pin   = pins[PIN_RR];
            r.left_duty       = left_duty;
            r.right_duty      = right_duty;
            r.average_speed   = 9'(avg);
            r.drive_state     = drive_state;
            expected_q.insert(expected_q.size(), r);
        endfunction

        function void check_result(t_drive_res got);
            t_drive_res exp;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result word with nothing expected", $realtime);
                end
                return;
            end
            exp = expected_q.pop_front();
            if (got.left_fwd_pin !== exp.left_fwd_pin || got.left_rev_pin !== exp.left_rev_pin
                || got.right_fwd_pin !== exp.right_fwd_pin
                || got.right_rev_pin !== exp.right_rev_pin
                || got.left_duty !== exp.left_duty || got.right_duty !== exp.right_duty
                || got.average_speed !== exp.average_speed
                || got.drive_state !== exp.drive_state) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: exp pins %b%b%b%b duty %0d/%0d avg %0d state %0d",
                             $realtime, exp.left_fwd_pin, exp.left_rev_pin,
                             exp.right_fwd_pin, exp.right_rev_pin, exp.left_duty,
                             exp.right_duty, exp.average_speed, exp.drive_state);
                    $display("%0t: got pins %b%b%b%b duty %0d/%0d avg %0d state %0d",
                             $realtime, got.left_fwd_pin, got.left_rev_pin,
                             got.right_fwd_pin, got.right_rev_pin, got.left_duty,
                             got.right_duty, got.average_speed, got.drive_state);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_idx;
    logic [6:0] i_cfg_data;

    dhbd_cmd_if cmd_bus();
    dhbd_res_if res_bus();

    dual_hbridge_drive_controller uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_bus),
        .o_res      (res_bus)
    );

    drive_scoreboard drive_sb = new();
    int send_idle_pct = 0;
    int stall_pct     = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // result channel: check accepted words, pick ready for the next cycle
    always @(posedge i_clk) begin
        t_drive_res got;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            got.left_fwd_pin  = res_bus.left_fwd_pin;
            got.left_rev_pin  = res_bus.left_rev_pin;
            got.right_fwd_pin = res_bus.right_fwd_pin;
            got.right_rev_pin = res_bus.right_rev_pin;
            got.left_duty     = res_bus.left_duty;
            got.right_duty    = res_bus.right_duty;
            got.average_speed = res_bus.average_speed;
            got.drive_state   = res_bus.drive_state;
            drive_sb.check_result(got);
        end
        res_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    function automatic t_drive_cmd random_command();
        t_drive_cmd c;
        c.mode      = t_mode'($urandom_range(0, 7));
        c.speed     = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, 100))
                                                   : 7'($urandom_range(101, 127));
        c.direction = 1'($urandom_range(0, 1));
        c.tightness = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, 100))
                                                   : 7'($urandom_range(101, 127));
        c.amount    = 7'($urandom_range(0, 127));
        c.turning   = 8'($urandom);
        return c;
    endfunction

    // valid stays high from one word to the next unless a gap is taken
    task automatic send_command(input t_drive_cmd c);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            cmd_bus.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        cmd_bus.valid     <= 1'b1;
        cmd_bus.mode      <= c.mode;
        cmd_bus.speed     <= c.speed;
        cmd_bus.direction <= c.direction;
        cmd_bus.tightness <= c.tightness;
        cmd_bus.amount    <= c.amount;
        cmd_bus.turning   <= c.turning;
        do @(posedge i_clk); while (!cmd_bus.ready);
        drive_sb.note_command(c);
    endtask

    task automatic issue(input t_mode m, input int spd, input logic dir, input int tgt,
                         input int amt, input int trn);
        t_drive_cmd c;
        c.mode      = m;
        c.speed     = 7'(spd);
        c.direction = dir;
        c.tightness = 7'(tgt);
        c.amount    = 7'(amt);
        c.turning   = 8'(trn);
        send_command(c);
    endtask

    task automatic drain();
        cmd_bus.valid <= 1'b0;
        while (drive_sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_scales(input logic [6:0] left, input logic [6:0] right);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_LEFT_SCALE;
        i_cfg_data <= left;
        @(posedge i_clk);
        drive_sb.set_scale(CFG_LEFT_SCALE, left);
        i_cfg_idx  <= CFG_RIGHT_SCALE;
        i_cfg_data <= right;
        @(posedge i_clk);
        drive_sb.set_scale(CFG_RIGHT_SCALE, right);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int         idle_tab[4]  = '{0, 57, 0, 22};
        int         stall_tab[4] = '{0, 0, 57, 22};
        logic [6:0] left_tab[4]  = '{7'd100, 7'd127, 7'd0, 7'd55};
        logic [6:0] right_tab[4] = '{7'd0, 7'd63, 7'd100, 7'd127};
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= CFG_LEFT_SCALE;
        i_cfg_data        <= '0;
        cmd_bus.valid     <= 1'b0;
        cmd_bus.mode      <= MODE_STOP;
        cmd_bus.speed     <= '0;
        cmd_bus.direction <= 1'b0;
        cmd_bus.tightness <= '0;
        cmd_bus.amount    <= '0;
        cmd_bus.turning   <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words at reset scales
        issue(MODE_STOP,     0,   1'b0, 0,   0,   0);
        issue(MODE_FORWARD,  100, 1'b0, 0,   0,   0);
        issue(MODE_FORWARD,  127, 1'b1, 127, 127, -1);
        issue(MODE_BACKWARD, 0,   1'b0, 0,   0,   0);
        issue(MODE_BACKWARD, 55,  1'b1, 3,   9,   7);
        issue(MODE_SPIN,     100, 1'b0, 0,   0,   0);
        issue(MODE_SPIN,     127, 1'b1, 0,   0,   0);
        issue(MODE_GRADUAL,  100, 1'b1, 0,   0,   0);
        issue(MODE_GRADUAL,  100, 1'b0, 100, 0,   0);
        issue(MODE_GRADUAL,  127, 1'b1, 127, 0,   0);
        issue(MODE_GRADUAL,  73,  1'b0, 37,  0,   0);
        issue(MODE_STEER,    0,   1'b0, 0,   0,   127);
        issue(MODE_STEER,    0,   1'b0, 0,   0,   -128);
        issue(MODE_STEER,    0,   1'b0, 0,   0,   0);
        // push held speeds into positive then negative saturation
        repeat (3) issue(MODE_FAST, 0, 1'b0, 0, 127, 0);
        repeat (5) issue(MODE_SLOW, 0, 1'b0, 0, 127, 0);
        issue(MODE_SLOW,     0,   1'b0, 0,   0,   0);
        issue(MODE_STOP,     127, 1'b1, 127, 127, -128);

        for (int ph = 0; ph < 4; ph++) begin
            drain();
            write_scales(left_tab[ph], right_tab[ph]);
            send_idle_pct = idle_tab[ph];
            stall_pct     = stall_tab[ph];
            for (int n = 0; n < 232; n++) begin
                if (n == 116) begin
                    // idle the sender until all words are back, then rescale
                    drain();
                    write_scales(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
                end
                send_command(random_command());
            end
        end

        drain();
        if (drive_sb.pending() != 0) begin
            drive_sb.mismatches++;
        end
        if (drive_sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* dual_hbridge_drive_controller.f */
src/dhbd_pkg.sv
src/dhbd_if.sv
src/dhbd_ctrl.sv
src/dhbd_dp.sv
src/dual_hbridge_drive_controller.sv
src/dhbd_chk.sv
verif/tb_top.sv
